// File: hdl/quadratic_interp_resampler_defines.svh
// ----------------------------------------------------------------------------
// Quadratic interpolation resampler - assertion macros
// Shared assertion helpers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef QUADRATIC_INTERP_RESAMPLER_DEFINES_SVH
`define QUADRATIC_INTERP_RESAMPLER_DEFINES_SVH

`ifndef SYNTHESIS
`define QIR_ASSERT(name, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
`define QIR_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define QIR_ASSERT(name, expr)
`define QIR_ASSERT_NEXT(name, ante, cons)
`endif

`endif

// File: hdl/qir_pkg.sv
// ----------------------------------------------------------------------------
// Quadratic interpolation resampler - package
// Field widths, register indexes and default sizes.
// ----------------------------------------------------------------------------
package qir_pkg;

    localparam int SAMPLE_W       = 16;
    localparam int STEP_W         = 20;
    localparam int OUT_COUNT_W    = 24;
    localparam int CFG_IDX_W      = 1;
    localparam int CFG_DATA_W     = 24;
    localparam int MAX_RESULTS    = 16;
    localparam int RES_CNT_W      = 5;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int COUNT_BITS_DEF = 24;
    localparam int SAMPLE_MAX     = 32767;
    localparam int SAMPLE_MIN     = -32768;

    localparam logic [STEP_W-1:0] STEP_RESET = 20'd65536;

    localparam logic [CFG_IDX_W-1:0] REG_STEP      = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_COUNT = 1'd1;

endpackage

// File: hdl/qir_mul.sv
// ----------------------------------------------------------------------------
// Quadratic interpolation resampler - shared multiplier
// Signed multiply with a registered product.
// ----------------------------------------------------------------------------
module qir_mul #(
    parameter int A_W = 18,
    parameter int B_W = 20
) (
    input  logic                       clk,
    input  logic signed [A_W-1:0]      a,
    input  logic signed [B_W-1:0]      b,
    output logic signed [A_W+B_W-1:0]  product
);

    logic signed [A_W+B_W-1:0] product_reg;

    always_ff @(posedge clk)
    begin
        product_reg <= a * b;
    end

    assign product = product_reg;

endmodule

// File: hdl/quadratic_interp_resampler.sv
// ----------------------------------------------------------------------------
// Quadratic interpolation resampler - top level
// Mono 16-bit rate converter fitting a quadratic through three samples.
// ----------------------------------------------------------------------------
//  channel   dir  signals                        contents
//  s_axis    in   tvalid/tready/tdata/tlast      tdata = sample_in, tlast = end_of_stream
//  m_axis    out  tvalid/tready/tdata/tlast      tdata = sample_out, tlast = last_of_run
//  cfg       in   cfg_we/cfg_index/cfg_wdata     0 = step, 1 = out_count
//
//  An item yields n results, n = 0..16. Each result takes a window check,
//  three passes through the one shared multiplier, a combine step and a
//  saturate/load step. Output stalls hold the sequencer at the load step;
//  s_axis_tready is low while an item is in work. Reset clears the stream
//  state at once.
// ----------------------------------------------------------------------------
`include "quadratic_interp_resampler_defines.svh"

module quadratic_interp_resampler #(
    parameter int FRAC_BITS  = qir_pkg::FRAC_BITS_DEF,
    parameter int COUNT_BITS = qir_pkg::COUNT_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [qir_pkg::SAMPLE_W-1:0]     s_axis_tdata,   // [15:0] sample_in
    input  logic                             s_axis_tlast,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [qir_pkg::SAMPLE_W-1:0]     m_axis_tdata,   // [15:0] sample_out
    output logic                             m_axis_tlast,
    input  logic                             cfg_we,
    input  logic [qir_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [qir_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    localparam int F      = FRAC_BITS;
    localparam int C      = COUNT_BITS;
    localparam int SW     = qir_pkg::SAMPLE_W;
    localparam int POS_W  = C + F;
    localparam int PA_W   = F + 2;
    localparam int BW     = (F + 1 > 20) ? F + 1 : 20;
    localparam int PW     = PA_W + BW;
    localparam int MW     = PW + 1;
    localparam int KW     = C + 2;
    localparam int LIM_W  = (C > qir_pkg::OUT_COUNT_W) ? C : qir_pkg::OUT_COUNT_W;
    localparam int YW     = BW + 4;
    localparam int NW     = qir_pkg::RES_CNT_W;

    localparam logic signed [YW-1:0] Y_MAX = YW'(qir_pkg::SAMPLE_MAX);
    localparam logic signed [YW-1:0] Y_MIN = YW'(qir_pkg::SAMPLE_MIN);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MUL_E,
        ST_MUL_H,
        ST_MUL_L,
        ST_COMB,
        ST_OUT
    } state_t;

    state_t                        state_reg;
    logic signed [SW-1:0]          win_reg [3];
    logic [C-1:0]                  seen_reg;
    logic [POS_W-1:0]              pos_reg;
    logic [C-1:0]                  done_reg;
    logic [NW-1:0]                 n_reg;
    logic                          eos_reg;
    logic [qir_pkg::STEP_W-1:0]    step_reg;
    logic [qir_pkg::OUT_COUNT_W-1:0] out_count_reg;
    logic                          out_valid_reg;
    logic [SW-1:0]                 out_data_reg;
    logic                          out_last_reg;

    logic signed [SW-1:0]          s1_reg;
    logic signed [BW-1:0]          d_reg;
    logic signed [BW-1:0]          e_reg;
    logic [F:0]                    p_reg;
    logic [F-1:0]                  al_reg;
    logic signed [PW-1:0]          h_reg;
    logic signed [MW-1:0]          m_reg;
    logic                          rem_reg;

    // position / window selection
    logic [C-1:0]                  ip;
    logic [C-1:0]                  base;
    logic [KW-1:0]                 k;
    logic [KW-1:0]                 kj [3];
    logic [1:0]                    rel [3];
    logic signed [SW-1:0]          sel [3];
    logic signed [BW-1:0]          s1x;
    logic signed [BW-1:0]          s2x;
    logic signed [BW-1:0]          s3x;
    logic signed [BW-1:0]          d_next;
    logic signed [BW-1:0]          e_next;
    logic [F:0]                    p_next;
    logic [LIM_W-1:0]              oc_ext;
    logic [LIM_W-1:0]              cmax;
    logic [LIM_W-1:0]              lim;
    logic                          room;
    logic                          window_short;
    logic                          go;
    logic [C-1:0]                  seen_next;
    logic [POS_W:0]                pos_sum;
    logic [POS_W-1:0]              pos_next;

    // shared multiplier
    logic signed [PA_W-1:0]        mul_a;
    logic signed [BW-1:0]          mul_b;
    logic signed [PW-1:0]          mul_prod;
    logic signed [BW-1:0]          ah;

    // combine / saturate
    logic signed [MW-1:0]          m_next;
    logic signed [YW-1:0]          f_val;
    logic                          rem_all;
    logic signed [YW-1:0]          y0;
    logic signed [YW-1:0]          y1;
    logic [SW-1:0]                 y_sat;
    logic                          out_free;

    always_comb
    begin
        ip   = pos_reg[POS_W-1:F];
        base = (ip == '0) ? '0 : ip - C'(1);
        k    = {2'b00, base} + KW'(3) - {2'b00, seen_reg};
        for (int j = 0; j < 3; j++)
        begin
            kj[j] = k + KW'(j);
            if (kj[j][KW-1])
                rel[j] = 2'd0;
            else if (kj[j] >= KW'(2))
                rel[j] = 2'd2;
            else
                rel[j] = kj[j][1:0];
            sel[j] = win_reg[rel[j]];
        end
        s1x    = BW'(sel[0]);
        s2x    = BW'(sel[1]);
        s3x    = BW'(sel[2]);
        d_next = (s2x <<< 2) - s1x - (s1x <<< 1) - s3x;
        e_next = s1x - (s2x <<< 1) + s3x;
        p_next = {ip != '0, pos_reg[F-1:0]};

        oc_ext = LIM_W'(out_count_reg);
        cmax   = LIM_W'({C{1'b1}});
        lim    = (oc_ext < cmax) ? oc_ext : cmax;
        room   = LIM_W'(done_reg) < lim;
        window_short = !k[KW-1] && (k != '0);
        go = (n_reg < NW'(qir_pkg::MAX_RESULTS)) && room && (eos_reg || !window_short);

        seen_next = (seen_reg == {C{1'b1}}) ? seen_reg : seen_reg + C'(1);
        pos_sum   = {1'b0, pos_reg} + (POS_W + 1)'(step_reg);
        pos_next  = pos_sum[POS_W] ? {POS_W{1'b1}} : pos_sum[POS_W-1:0];
    end

    assign ah    = BW'(mul_prod >>> F);
    assign mul_a = $signed({1'b0, p_reg});

    always_comb
    begin
        case (state_reg)
            ST_MUL_E: mul_b = e_reg;
            ST_MUL_H: mul_b = d_reg + ah;
            ST_MUL_L: mul_b = BW'(al_reg);
            default:  mul_b = e_reg;
        endcase
    end

    qir_mul #(
        .A_W (PA_W),
        .B_W (BW)
    ) u_mul (
        .clk     (clk),
        .a       (mul_a),
        .b       (mul_b),
        .product (mul_prod)
    );

    always_comb
    begin
        m_next  = MW'(h_reg) + MW'(mul_prod >>> F);
        f_val   = YW'(m_reg >>> (F + 1));
        rem_all = rem_reg || (m_reg[F:0] != '0);
        y0      = YW'(s1_reg) + f_val;
        y1      = (rem_all && y0[YW-1]) ? y0 + YW'(1) : y0;
        if (y1 > Y_MAX)
            y_sat = SW'(Y_MAX);
        else if (y1 < Y_MIN)
            y_sat = SW'(Y_MIN);
        else
            y_sat = SW'(y1);
        out_free = !out_valid_reg || m_axis_tready;
    end

    // datapath holding registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_CHECK:
            begin
                s1_reg <= sel[0];
                d_reg  <= d_next;
                e_reg  <= e_next;
                p_reg  <= p_next;
            end
            ST_MUL_H: al_reg <= mul_prod[F-1:0];
            ST_MUL_L: h_reg  <= mul_prod;
            ST_COMB:
            begin
                m_reg   <= m_next;
                rem_reg <= mul_prod[F-1:0] != '0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            for (int j = 0; j < 3; j++)
                win_reg[j] <= '0;
            seen_reg      <= '0;
            pos_reg       <= '0;
            done_reg      <= '0;
            n_reg         <= '0;
            eos_reg       <= 1'b0;
            step_reg      <= qir_pkg::STEP_RESET;
            out_count_reg <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    qir_pkg::REG_STEP:      step_reg      <= cfg_wdata[qir_pkg::STEP_W-1:0];
                    qir_pkg::REG_OUT_COUNT: out_count_reg <= cfg_wdata;
                    default:
                    begin
                    end
                endcase
            end
            if (state_reg == ST_OUT && out_free)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        win_reg[0] <= win_reg[1];
                        win_reg[1] <= win_reg[2];
                        win_reg[2] <= s_axis_tdata;
                        seen_reg   <= seen_next;
                        eos_reg    <= s_axis_tlast;
                        n_reg      <= '0;
                        state_reg  <= ST_CHECK;
                    end
                end
                ST_CHECK:
                begin
                    if (go)
                    begin
                        done_reg  <= done_reg + C'(1);
                        pos_reg   <= pos_next;
                        n_reg     <= n_reg + NW'(1);
                        state_reg <= ST_MUL_E;
                    end
                    else
                    begin
                        if (eos_reg)
                        begin
                            for (int j = 0; j < 3; j++)
                                win_reg[j] <= '0;
                            seen_reg <= '0;
                            pos_reg  <= '0;
                            done_reg <= '0;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                ST_MUL_E: state_reg <= ST_MUL_H;
                ST_MUL_H: state_reg <= ST_MUL_L;
                ST_MUL_L: state_reg <= ST_COMB;
                ST_COMB:  state_reg <= ST_OUT;
                ST_OUT:
                begin
                    if (out_free)
                    begin
                        out_data_reg  <= y_sat;
                        out_last_reg  <= !go;
                        state_reg     <= ST_CHECK;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

    `QIR_ASSERT(a_result_cap, n_reg <= NW'(qir_pkg::MAX_RESULTS))
    `QIR_ASSERT_NEXT(a_accept_starts_check, s_axis_tvalid && s_axis_tready, state_reg == ST_CHECK)
    `QIR_ASSERT_NEXT(a_load_shows_item, state_reg == ST_OUT && out_free, m_axis_tvalid)

endmodule
